/* rtl/urxf_pkg.sv */
// urxf_pkg: shared constants, codes and types of the uart receiver with fifo
// no dependencies
`timescale 1ns / 1ps

package urxf_pkg;

  localparam int unsigned FIFO_DEPTH_DEFAULT = 128;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned COUNT_W = 4;
  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RESET = 16'd868;
  localparam logic [COUNT_W-1:0] COUNT_DATA_LAST = 4'd8;

  typedef enum logic [0:0] {
    REG_BIT_PERIOD = 1'b0
  } reg_index_t;

  typedef enum logic {
    RX_IDLE,
    RX_BUSY
  } rx_state_t;

  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } fifo_wr_t;

  typedef struct packed {
    logic avail;
    logic rd_valid;
  } pop_status_t;

endpackage

/* rtl/urxf_if.sv */
// urxf_if: valid/ready channel interfaces for line samples and fifo results
// no dependencies
`timescale 1ns / 1ps

interface urxf_in_if;
  logic valid;
  logic ready;
  logic rx_level;
  logic pop_req;

  modport source (output valid, output rx_level, output pop_req, input ready);
  modport sink (input valid, input rx_level, input pop_req, output ready);
endinterface

interface urxf_out_if;
  logic       valid;
  logic       ready;
  logic       avail;
  logic       rd_valid;
  logic [7:0] rd_data;

  modport source (output valid, output avail, output rd_valid, output rd_data, input ready);
  modport sink (input valid, input avail, input rd_valid, input rd_data, output ready);
endinterface

/* rtl/uart_receiver_with_fifo.sv */
// uart_receiver_with_fifo: 8n1 serial receiver feeding a ring fifo, apb setup
// depends on urxf_pkg, urxf_if, urxf_rx, urxf_fifo and urxf_ram
//
// usage:
//   sample channel: one transaction per clock tick of the serial line, carrying
//   the sampled line level and a request to pop one byte from the fifo.
//   result channel: one transaction per sample transaction, in order: avail
//   (fifo held a byte before the tick), rd_valid and rd_data (zero if no pop).
//   apb port: register 0 at address 0 is bit_period, clock ticks per serial
//   bit; the frame timing counts sample transactions, not raw clocks.
// path: a result passes the ram read stage, then the output register, after its sample.
// throughput: one transaction per cycle while result.ready is high, set by the two-stage
//   result pipeline (ram read stage, output register); the ram read stage lets one more
//   sample in while a result waits on the output.
// reset: receiver idle, fifo empty, bit_period back to 868; no ram clearing.
// stall: with result.ready low, one more sample is taken, then sample.ready
//   drops until the output register is drained.
`timescale 1ns / 1ps

module uart_receiver_with_fifo #(
  parameter int unsigned FIFO_DEPTH = urxf_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  urxf_in_if.sink                           sample,
  urxf_out_if.source                        result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [urxf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [urxf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [urxf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  import urxf_pkg::*;

  logic [PERIOD_W-1:0] bit_period;
  logic                cfg_wr;
  reg_index_t          reg_sel;
  logic                step;
  logic                s1_move;
  logic                s1_valid;
  pop_status_t         s1_status;
  pop_status_t         status;
  logic                o_valid;
  logic                o_avail;
  logic                o_rd_valid;
  logic [7:0]          o_rd_data;
  logic [7:0]          rd_q;
  fifo_wr_t            wr;

  // configuration
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_index_t'(paddr[APB_ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= BIT_PERIOD_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_BIT_PERIOD: bit_period <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BIT_PERIOD: prdata = {{(APB_DATA_W-PERIOD_W){1'b0}}, bit_period};
      default:        prdata = '0;
    endcase
  end

  // handshake
  assign s1_move      = s1_valid && (!o_valid || result.ready);
  assign sample.ready = !s1_valid || s1_move;
  assign step         = sample.valid && sample.ready;

  urxf_rx u_rx (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rx_level   (sample.rx_level),
    .bit_period (bit_period),
    .wr         (wr)
  );

  urxf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .pop_req (sample.pop_req),
    .wr      (wr),
    .status  (status),
    .rd_q    (rd_q)
  );

  // ram read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (step) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) s1_status <= status;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_move) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      o_avail    <= s1_status.avail;
      o_rd_valid <= s1_status.rd_valid;
      o_rd_data  <= s1_status.rd_valid ? rd_q : 8'd0;
    end
  end

  assign result.valid    = o_valid;
  assign result.avail    = o_avail;
  assign result.rd_valid = o_rd_valid;
  assign result.rd_data  = o_rd_data;

endmodule

/* rtl/urxf_ram.sv */
// urxf_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module urxf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

/* rtl/urxf_rx.sv */
// urxf_rx: 8n1 receive framing, bit timer and shift register
// depends on urxf_pkg
`timescale 1ns / 1ps

module urxf_rx (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic                              rx_level,
  input  logic [urxf_pkg::PERIOD_W-1:0]     bit_period,
  output urxf_pkg::fifo_wr_t                wr
);

  import urxf_pkg::*;

  rx_state_t           state;
  rx_state_t           state_next;
  logic [PERIOD_W-1:0] bit_timer;
  logic [PERIOD_W-1:0] bit_timer_next;
  logic [COUNT_W-1:0]  bit_count;
  logic [COUNT_W-1:0]  bit_count_next;
  logic [7:0]          shift_reg;
  logic [7:0]          shift_reg_next;
  logic                frame_event;

  assign frame_event = (bit_timer <= PERIOD_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      RX_IDLE: begin
        if (!rx_level) state_next = RX_BUSY;
      end
      RX_BUSY: begin
        if (frame_event && (bit_count > COUNT_DATA_LAST)) state_next = RX_IDLE;
      end
      default: state_next = RX_IDLE;
    endcase
  end

  always_comb begin
    bit_timer_next = bit_timer;
    bit_count_next = bit_count;
    shift_reg_next = shift_reg;
    wr.en          = 1'b0;
    wr.data        = shift_reg;
    unique case (state)
      RX_IDLE: begin
        if (!rx_level) begin
          bit_count_next = '0;
          shift_reg_next = '0;
          bit_timer_next = bit_period >> 1;
        end
      end
      RX_BUSY: begin
        priority if (!frame_event) begin
          bit_timer_next = bit_timer - PERIOD_W'(1);
        end else if (bit_count == '0) begin
          bit_count_next = COUNT_W'(1);
          bit_timer_next = bit_period;
        end else if (bit_count <= COUNT_DATA_LAST) begin
          shift_reg_next = {rx_level, shift_reg[7:1]};
          bit_count_next = bit_count + COUNT_W'(1);
          bit_timer_next = bit_period;
        end else begin
          // stop bit position: hand the byte to the fifo
          wr.en          = step;
          bit_count_next = '0;
          bit_timer_next = '0;
        end
      end
      default: begin
        bit_timer_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= RX_IDLE;
      bit_timer <= '0;
      bit_count <= '0;
      shift_reg <= '0;
    end else if (step) begin
      state     <= state_next;
      bit_timer <= bit_timer_next;
      bit_count <= bit_count_next;
      shift_reg <= shift_reg_next;
    end
  end

endmodule

/* rtl/urxf_fifo.sv */
// urxf_fifo: ring fifo pointers around a registered-read ram, no full check
// depends on urxf_pkg and urxf_ram
`timescale 1ns / 1ps

module urxf_fifo #(
  parameter int unsigned DEPTH = urxf_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  pop_req,
  input  urxf_pkg::fifo_wr_t    wr,
  output urxf_pkg::pop_status_t status,
  output logic [7:0]            rd_q
);

  import urxf_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             have;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign have            = (rd_ptr != wr_ptr);
  assign do_pop          = step && pop_req && have;
  assign status.avail    = have;
  assign status.rd_valid = pop_req && have;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (wr.en) wr_ptr <= ptr_inc(wr_ptr);
      if (do_pop) rd_ptr <= ptr_inc(rd_ptr);
    end
  end

  urxf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr_ptr),
    .wdata (wr.data),
    .re    (do_pop),
    .raddr (rd_ptr),
    .q     (rd_q)
  );

endmodule

/* rtl/urxf_chk.sv */
// urxf_chk: port-level checks of the uart receiver with fifo, bound to the top
// depends on uart_receiver_with_fifo
`timescale 1ns / 1ps

module urxf_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_avail,
  input logic       out_rd_valid,
  input logic [7:0] out_rd_data
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // an empty output register never blocks samples
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("sample blocked with empty output");

  // a pop can only succeed on a nonempty fifo
  a_pop_avail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rd_valid) |-> out_avail)
    else $error("pop succeeded on empty fifo");

  // failed pops return zero
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_rd_valid) |-> (out_rd_data == 8'd0))
    else $error("nonzero data without a pop");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_rd_data) && $stable(out_rd_valid) && $stable(out_avail)))
    else $error("stalled result changed");

endmodule

bind uart_receiver_with_fifo urxf_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample.valid),
  .in_ready     (sample.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_avail    (result.avail),
  .out_rd_valid (result.rd_valid),
  .out_rd_data  (result.rd_data)
);
